// ===== design/rcsd_pkg.sv =====
// rcsd_pkg: shared types, register indexes, reset values and command
// decoding for the rc command setpoint decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcsd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ANGLE_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_ALTITUDE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_MS     = 2'd2;

  localparam logic [6:0]  ANGLE_LIMIT_RST    = 7'd30;
  localparam logic [7:0]  ALTITUDE_LIMIT_RST = 8'd100;
  localparam logic [15:0] TIMEOUT_MS_RST     = 16'd500;

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  // item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // ascii codes
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_Q = 8'h51;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_X = 8'h58;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PITCH_UP,
    CMD_PITCH_DN,
    CMD_ROLL_UP,
    CMD_ROLL_DN,
    CMD_YAW_UP,
    CMD_YAW_DN,
    CMD_ALT_UP,
    CMD_ALT_DN,
    CMD_ZERO
  } cmd_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } item_t;

  // roll sits in the lowest bits
  typedef struct packed {
    logic              link_lost;
    logic [7:0]        altitude;
    logic signed [7:0] yaw;
    logic signed [7:0] pitch;
    logic signed [7:0] roll;
  } result_t;

  function automatic cmd_e decode_cmd(input logic [7:0] b);
    logic [7:0] up;
    cmd_e       c;
    up = ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ? (b - CASE_DIFF) : b;
    unique case (up)
      CH_W:    c = CMD_PITCH_UP;
      CH_S:    c = CMD_PITCH_DN;
      CH_D:    c = CMD_ROLL_UP;
      CH_A:    c = CMD_ROLL_DN;
      CH_E:    c = CMD_YAW_UP;
      CH_Q:    c = CMD_YAW_DN;
      CH_T:    c = CMD_ALT_UP;
      CH_G:    c = CMD_ALT_DN;
      CH_X:    c = CMD_ZERO;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/rcsd_in_reg.sv =====
// rcsd_in_reg: decoder input register, takes one beat per cycle when empty
// or when the result stage can take its item; uses rcsd_pkg for item type
`timescale 1ns / 1ps
`default_nettype none

module rcsd_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rcsd_pkg::item_t in_item_i,
  input  wire logic           adv_ok_i,
  output logic                item_valid_o,
  output rcsd_pkg::item_t     item_o
);

  logic            vld_q, vld_d;
  rcsd_pkg::item_t item_q;

  // register drains when the result stage can take its item
  assign in_ready_o   = !vld_q || adv_ok_i;
  assign vld_d        = in_ready_o ? in_valid_i : vld_q;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/rcsd_core.sv =====
// rcsd_core: configuration registers, setpoint and idle state, and the
// per-item update logic; uses rcsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcsd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_addr_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            fire_i,
  input  wire rcsd_pkg::item_t item_i,
  output rcsd_pkg::result_t    result_o
);

  logic [6:0]        angle_lim_q;
  logic [7:0]        alt_lim_q;
  logic [15:0]       timeout_q;
  logic signed [7:0] roll_q, pitch_q, yaw_q;
  logic signed [7:0] roll_d, pitch_d, yaw_d;
  logic [7:0]        alt_q, alt_d;
  logic [15:0]       idle_q, idle_d;
  rcsd_pkg::cmd_e    cmd;
  logic              is_byte;
  logic              lost;
  logic signed [7:0] roll_c, pitch_c, yaw_c;
  logic signed [9:0] alt_w;
  logic signed [9:0] alt_hi;

  // zero or step by one in a wider word, then clamp to +/- lim
  function automatic logic signed [7:0] step_angle(
    input logic signed [7:0] cur,
    input logic              up,
    input logic              dn,
    input logic              zero,
    input logic [6:0]        lim
  );
    logic signed [8:0] v;
    logic signed [8:0] hi;
    logic signed [8:0] lo;
    v  = {cur[7], cur};
    hi = $signed({2'b00, lim});
    lo = -hi;
    if (zero) begin
      v = 9'sd0;
    end else if (up) begin
      v = v + 9'sd1;
    end else if (dn) begin
      v = v - 9'sd1;
    end
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[7:0];
  endfunction

  assign is_byte = (item_i.kind == rcsd_pkg::KIND_BYTE);
  assign cmd     = rcsd_pkg::decode_cmd(item_i.rx_byte);

  assign roll_c  = step_angle(roll_q, cmd == rcsd_pkg::CMD_ROLL_UP,
                              cmd == rcsd_pkg::CMD_ROLL_DN,
                              cmd == rcsd_pkg::CMD_ZERO, angle_lim_q);
  assign pitch_c = step_angle(pitch_q, cmd == rcsd_pkg::CMD_PITCH_UP,
                              cmd == rcsd_pkg::CMD_PITCH_DN,
                              cmd == rcsd_pkg::CMD_ZERO, angle_lim_q);
  assign yaw_c   = step_angle(yaw_q, cmd == rcsd_pkg::CMD_YAW_UP,
                              cmd == rcsd_pkg::CMD_YAW_DN,
                              cmd == rcsd_pkg::CMD_ZERO, angle_lim_q);

  assign alt_hi = $signed({2'b00, alt_lim_q});

  always_comb begin
    alt_w = $signed({2'b00, alt_q});
    if (cmd == rcsd_pkg::CMD_ALT_UP) begin
      alt_w = alt_w + 10'sd1;
    end else if (cmd == rcsd_pkg::CMD_ALT_DN) begin
      alt_w = alt_w - 10'sd1;
    end
    if (alt_w > alt_hi) begin
      alt_w = alt_hi;
    end else if (alt_w < 10'sd0) begin
      alt_w = 10'sd0;
    end
  end

  always_comb begin
    if (is_byte) begin
      idle_d = '0;
    end else if (idle_q != rcsd_pkg::IDLE_MAX) begin
      idle_d = idle_q + 16'd1;
    end else begin
      idle_d = idle_q;
    end
    lost = (idle_d > timeout_q);

    // ticks never clamp; they advance the idle count and may trip link loss
    roll_d  = is_byte ? roll_c  : roll_q;
    pitch_d = is_byte ? pitch_c : pitch_q;
    yaw_d   = is_byte ? yaw_c   : yaw_q;
    alt_d   = is_byte ? alt_w[7:0] : alt_q;
    if (lost) begin
      roll_d  = '0;
      pitch_d = '0;
      yaw_d   = '0;
    end

    result_o.roll      = roll_d;
    result_o.pitch     = pitch_d;
    result_o.yaw       = yaw_d;
    result_o.altitude  = alt_d;
    result_o.link_lost = lost;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_lim_q <= rcsd_pkg::ANGLE_LIMIT_RST;
      alt_lim_q   <= rcsd_pkg::ALTITUDE_LIMIT_RST;
      timeout_q   <= rcsd_pkg::TIMEOUT_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rcsd_pkg::CFG_ANGLE_LIMIT:    angle_lim_q <= cfg_wdata_i[6:0];
        rcsd_pkg::CFG_ALTITUDE_LIMIT: alt_lim_q   <= cfg_wdata_i[7:0];
        rcsd_pkg::CFG_TIMEOUT_MS:     timeout_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
      alt_q   <= '0;
      idle_q  <= '0;
    end else if (fire_i) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      alt_q   <= alt_d;
      idle_q  <= idle_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rcsd_out_reg.sv =====
// rcsd_out_reg: result register holding one beat for the master side
// uses rcsd_pkg for the result type
`timescale 1ns / 1ps
`default_nettype none

module rcsd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire rcsd_pkg::result_t result_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rcsd_pkg::result_t      result_o
);

  logic              vld_q, vld_d;
  rcsd_pkg::result_t res_q;

  // free when empty or when the held beat leaves this cycle
  assign can_load_o  = !vld_q || out_ready_i;
  assign vld_d       = load_i ? 1'b1 : (vld_q && !out_ready_i);
  assign out_valid_o = vld_q;
  assign result_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/rc_command_setpoint_decoder.sv =====
// rc_command_setpoint_decoder: remote-control command byte decoder with
// setpoint clamping and link-loss timeout; uses rcsd_pkg, rcsd_in_reg,
// rcsd_core and rcsd_out_reg
//
// usage:
//   slave side takes one beat per item: tuser is the kind (0 received byte,
//   1 one-millisecond tick), tdata carries the byte. each beat yields one
//   master beat with roll, pitch, yaw, altitude and the link-lost flag.
//   configuration is a plain write port (index 0 angle limit, 1 altitude
//   limit, 2 timeout in ms); the user must see that it is written only while
//   no beat is in flight; the block itself does not enforce it.
// path: one input register and one result register with the setpoint update
//   between them; the result register drives master tvalid.
// throughput: one beat per cycle unless the master side stalls; the state
//   update is registered, so each item sees the state left by the last one.
// reset: setpoints and idle count clear to zero, limits load 30, 100, 500,
//   and both registers empty.
// stall: a held master beat keeps the result register; an empty input register
//   still takes one more beat, then s_axis_tready drops until tready returns.
`timescale 1ns / 1ps
`default_nettype none

module rc_command_setpoint_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic        s_axis_tuser,  // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] roll_out, [15:8] pitch_out, [23:16] yaw_out, [31:24] altitude_out,
  // [32] link_lost, [39:33] zero
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  rcsd_pkg::item_t   in_item;
  rcsd_pkg::item_t   cur_item;
  rcsd_pkg::result_t next_res;
  rcsd_pkg::result_t out_res;
  logic              cur_valid;
  logic              can_load;
  logic              fire;

  assign in_item.kind    = s_axis_tuser;
  assign in_item.rx_byte = s_axis_tdata;
  assign fire            = cur_valid && can_load;

  rcsd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .adv_ok_i     (can_load),
    .item_valid_o (cur_valid),
    .item_o       (cur_item)
  );

  rcsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (cur_item),
    .result_o    (next_res)
  );

  rcsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (next_res),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res};

endmodule

`default_nettype wire
